/* src/aavr_pkg.sv */
package aavr_pkg;

   // Pipeline depths of the two datapath units.
   localparam int TRIG_LAT = 19;
   localparam int ROT_LAT  = 4;

   // Register indexes on the configuration port.
   localparam logic [1:0] CSR_AXIS_X = 2'd0;
   localparam logic [1:0] CSR_AXIS_Y = 2'd1;
   localparam logic [1:0] CSR_AXIS_Z = 2'd2;

   // Angles in 1/256 degree.
   localparam logic signed [19:0] DEG360_S = 20'sd92160;
   localparam logic signed [19:0] DEG720_S = 20'sd184320;
   localparam logic [16:0] DEG90  = 17'd23040;
   localparam logic [16:0] DEG180 = 17'd46080;
   localparam logic [16:0] DEG270 = 17'd69120;
   localparam logic [16:0] DEG45  = 17'd11520;

   // round(pi * 2^32) split as 184320 * PI_INT + PI_FRAC.
   localparam logic [16:0] PI_INT   = 17'd73204;
   localparam logic [16:0] PI_FRAC  = 17'd76425;
   localparam logic [29:0] PI_RND   = 30'd92160;
   // ceil(2^24 / 45), exact for dividends below 2^18.
   localparam logic [18:0] RECIP45  = 19'd372828;

   localparam logic [30:0] ONE_Q30  = 31'h4000_0000;
   localparam logic [60:0] HALF_Q30 = 61'h2000_0000;

   // Horner divisors written as odd factor times a power of two.
   localparam int HORNER_SHIFT [6] = '{2, 1, 3, 1, 2, 1};
   localparam int SIN_ODD      [6] = '{39, 55, 9, 21, 5, 3};
   localparam int COS_ODD      [6] = '{33, 45, 7, 15, 3, 1};

   localparam logic signed [63:0] OUT_MAX = 64'sd262143;
   localparam logic signed [63:0] OUT_MIN = -64'sd262144;

   typedef enum logic [4:0] {
      NRM_SQUARE  = 5'b00001,
      NRM_ROOT    = 5'b00010,
      NRM_DIVIDE  = 5'b00100,
      NRM_PRODUCT = 5'b01000,
      NRM_READY   = 5'b10000
   } aavr_norm_state_type;

   // Normalised axis and its outer products, Q.30.
   typedef struct packed {
      logic               ready;
      logic               err;
      logic signed [31:0] u0;
      logic signed [31:0] u1;
      logic signed [31:0] u2;
      logic signed [31:0] uu00;
      logic signed [31:0] uu11;
      logic signed [31:0] uu22;
      logic signed [31:0] uu01;
      logic signed [31:0] uu02;
      logic signed [31:0] uu12;
   } aavr_axis_type;

   typedef struct packed {
      logic [1:0] quad;
      logic       swap;
   } aavr_quad_type;

   typedef struct packed {
      logic        err;
      logic [18:0] z;
      logic [18:0] y;
      logic [18:0] x;
   } aavr_result_type;

   // Divide by 2^30 rounding half away from zero.
   function automatic logic signed [63:0] rsh30(input logic signed [63:0] v);
      logic [63:0] mag;
      logic [63:0] rnd;
      mag = v[63] ? 64'(-v) : 64'(v);
      rnd = (mag + 64'h2000_0000) >> 30;
      return v[63] ? -$signed(rnd) : $signed(rnd);
   endfunction

endpackage

/* src/axis_angle_vector_rotation_unit.sv */
// Channel   Direction  tdata (low bit first)                      tuser
// req       in         vec_x, vec_y, vec_z, angle_deg (72 bits)   -
// rsp       out        out_x, out_y, out_z, zero pad (64 bits)    axis_error
// csr       in         csr_we, csr_addr, csr_wdata (axis x, y, z)
//
// One item per cycle while req_tready is high; each item passes through the
// sine/cosine and matrix pipelines before it reaches the output register.
// After reset and after every register write the axis normaliser runs
// (square root and three long divisions, one bit per cycle), ending after
// the sum of squares for a zero axis; req_tready stays low until it has finished.
// A skid register at the output holds one item, so the pipeline stalls only
// once that register is full; reset is synchronous.
module axis_angle_vector_rotation_unit import aavr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // vec_x, vec_y, vec_z, angle_deg
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // out_x, out_y, out_z, zero pad
   output logic [0:0]  rsp_tuser,   // axis_error
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [17:0] csr_wdata
);

   logic signed [17:0] axis_x_ff, axis_x_in;
   logic signed [17:0] axis_y_ff, axis_y_in;
   logic signed [17:0] axis_z_ff, axis_z_in;

   aavr_axis_type      axis;
   logic               en;
   logic               trig_vld;
   logic signed [31:0] sin_q30, cos_q30;
   logic signed [32:0] omc_q30;
   logic [53:0]        vec_dly_ff [TRIG_LAT];
   logic               rot_vld;
   aavr_result_type    rot_res;
   logic               skid_vld_ff, skid_vld_in;
   aavr_result_type    skid_ff;
   aavr_result_type    shown;

   // Axis registers.
   always_comb begin
      axis_x_in = axis_x_ff;
      axis_y_in = axis_y_ff;
      axis_z_in = axis_z_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_AXIS_X: axis_x_in = $signed(csr_wdata);
            CSR_AXIS_Y: axis_y_in = $signed(csr_wdata);
            CSR_AXIS_Z: axis_z_in = $signed(csr_wdata);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         axis_x_ff <= '0;
         axis_y_ff <= '0;
         axis_z_ff <= 18'sd65536;
      end else begin
         axis_x_ff <= axis_x_in;
         axis_y_ff <= axis_y_in;
         axis_z_ff <= axis_z_in;
      end
   end

   aavr_axis_norm u_norm (
      .clock (clock),
      .reset (reset),
      .start (csr_we),
      .axis_x(axis_x_ff),
      .axis_y(axis_y_ff),
      .axis_z(axis_z_ff),
      .axis  (axis)
   );

   // The pipeline moves whenever the skid register is free.
   assign en         = !skid_vld_ff;
   assign req_tready = en && axis.ready;

   aavr_trig u_trig (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_tvalid && req_tready),
      .angle    ($signed(req_tdata[71:54])),
      .out_valid(trig_vld),
      .sin_q30  (sin_q30),
      .cos_q30  (cos_q30),
      .omc_q30  (omc_q30)
   );

   // The vector waits alongside the sine and cosine pipeline.
   always_ff @(posedge clock) begin
      if (en) begin
         vec_dly_ff[0] <= req_tdata[53:0];
         for (int i = 1; i < TRIG_LAT; i++) begin
            vec_dly_ff[i] <= vec_dly_ff[i-1];
         end
      end
   end

   aavr_rotate u_rotate (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (trig_vld),
      .sin_q30  (sin_q30),
      .cos_q30  (cos_q30),
      .omc_q30  (omc_q30),
      .vec_x    ($signed(vec_dly_ff[TRIG_LAT-1][17:0])),
      .vec_y    ($signed(vec_dly_ff[TRIG_LAT-1][35:18])),
      .vec_z    ($signed(vec_dly_ff[TRIG_LAT-1][53:36])),
      .axis     (axis),
      .out_valid(rot_vld),
      .result   (rot_res)
   );

   // Skid register: catches the item that the consumer did not take.
   always_comb begin
      if (skid_vld_ff) begin
         skid_vld_in = !rsp_tready;
      end else begin
         skid_vld_in = rot_vld && !rsp_tready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_vld_ff <= 1'b0;
      end else begin
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!skid_vld_ff) begin
         skid_ff <= rot_res;
      end
   end

   assign shown      = skid_vld_ff ? skid_ff : rot_res;
   assign rsp_tvalid = skid_vld_ff || rot_vld;
   assign rsp_tdata  = {7'd0, shown.z, shown.y, shown.x};
   assign rsp_tuser  = shown.err;

`ifndef SYNTHESIS
   a_skid_holds: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff && !rsp_tready |=> skid_vld_ff && $stable(skid_ff))
      else $error("skid item lost while stalled");
   a_skid_catches: assert property (@(posedge clock) disable iff (reset)
      !skid_vld_ff && rot_vld && !rsp_tready |=> skid_vld_ff)
      else $error("stalled result not captured");
   a_write_restarts: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> !axis.ready)
      else $error("register write did not restart axis normalisation");
`endif

endmodule

/* src/aavr_axis_norm.sv */
module aavr_axis_norm import aavr_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [17:0] axis_x,
   input  logic signed [17:0] axis_y,
   input  logic signed [17:0] axis_z,
   output aavr_axis_type      axis
);

   aavr_norm_state_type state_ff, state_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [1:0]  comp_ff, comp_in;
   logic [35:0] n2_ff, n2_in;
   logic [31:0] root_ff, root_in;
   logic [33:0] rem_ff, rem_in;
   logic [63:0] num_ff, num_in;
   logic [61:0] quo_ff, quo_in;
   logic        err_ff, err_in;
   logic signed [31:0] u0_ff, u0_in, u1_ff, u1_in, u2_ff, u2_in;
   logic signed [31:0] uu00_ff, uu00_in, uu11_ff, uu11_in, uu22_ff, uu22_in;
   logic signed [31:0] uu01_ff, uu01_in, uu02_ff, uu02_in, uu12_ff, uu12_in;

   logic signed [17:0] a_sel;
   logic signed [35:0] sq;
   logic [17:0] mag;
   logic [35:0] rem2, trial;
   logic        ge;
   logic [32:0] drem2;
   logic [61:0] dnum;
   logic [30:0] uq;
   logic signed [31:0] uval;
   logic signed [31:0] pa, pb;
   logic signed [63:0] pr;

   // Sequencer: sum of squares, square root, three divisions, outer products.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      comp_in  = comp_ff;
      n2_in    = n2_ff;
      root_in  = root_ff;
      rem_in   = rem_ff;
      num_in   = num_ff;
      quo_in   = quo_ff;
      err_in   = err_ff;
      u0_in = u0_ff; u1_in = u1_ff; u2_in = u2_ff;
      uu00_in = uu00_ff; uu11_in = uu11_ff; uu22_in = uu22_ff;
      uu01_in = uu01_ff; uu02_in = uu02_ff; uu12_in = uu12_ff;

      case (comp_ff)
         2'd0:    a_sel = axis_x;
         2'd1:    a_sel = axis_y;
         default: a_sel = axis_z;
      endcase
      sq    = a_sel * a_sel;
      mag   = a_sel[17] ? 18'(-a_sel) : 18'(a_sel);
      rem2  = {rem_ff, num_ff[63:62]};
      trial = {2'b00, root_ff, 2'b01};
      drem2 = {rem_ff[31:0], num_ff[63]};
      dnum  = {mag, 44'd0} + 62'(root_ff >> 1);
      ge    = 1'b0;
      uq    = '0;
      uval  = '0;

      case (cnt_ff)
         6'd0:    begin pa = u0_ff; pb = u0_ff; end
         6'd1:    begin pa = u1_ff; pb = u1_ff; end
         6'd2:    begin pa = u2_ff; pb = u2_ff; end
         6'd3:    begin pa = u0_ff; pb = u1_ff; end
         6'd4:    begin pa = u0_ff; pb = u2_ff; end
         default: begin pa = u1_ff; pb = u2_ff; end
      endcase
      pr = rsh30(64'(pa) * 64'(pb));

      unique case (state_ff)
         NRM_SQUARE: begin
            n2_in = n2_ff + 36'(sq);
            if (comp_ff == 2'd2) begin
               comp_in = '0;
               if (n2_in == '0) begin
                  err_in   = 1'b1;
                  state_in = NRM_READY;
               end else begin
                  num_in   = {n2_in, 28'd0};
                  root_in  = '0;
                  rem_in   = '0;
                  cnt_in   = '0;
                  state_in = NRM_ROOT;
               end
            end else begin
               comp_in = comp_ff + 2'd1;
            end
         end
         NRM_ROOT: begin
            ge      = rem2 >= trial;
            rem_in  = ge ? 34'(rem2 - trial) : 34'(rem2);
            root_in = {root_ff[30:0], ge};
            num_in  = num_ff << 2;
            cnt_in  = cnt_ff + 6'd1;
            if (cnt_ff == 6'd31) begin
               cnt_in   = '0;
               comp_in  = '0;
               state_in = NRM_DIVIDE;
            end
         end
         NRM_DIVIDE: begin
            if (cnt_ff == 6'd0) begin
               num_in = {dnum, 2'd0};
               rem_in = '0;
               cnt_in = 6'd1;
            end else begin
               ge     = drem2 >= {1'b0, root_ff};
               rem_in = ge ? 34'(drem2 - {1'b0, root_ff}) : 34'(drem2);
               num_in = num_ff << 1;
               quo_in = {quo_ff[60:0], ge};
               cnt_in = cnt_ff + 6'd1;
               if (cnt_ff == 6'd62) begin
                  uq   = (quo_in > 62'(ONE_Q30)) ? ONE_Q30 : quo_in[30:0];
                  uval = a_sel[17] ? -$signed({1'b0, uq}) : $signed({1'b0, uq});
                  case (comp_ff)
                     2'd0:    u0_in = uval;
                     2'd1:    u1_in = uval;
                     default: u2_in = uval;
                  endcase
                  cnt_in = '0;
                  if (comp_ff == 2'd2) begin
                     state_in = NRM_PRODUCT;
                  end else begin
                     comp_in = comp_ff + 2'd1;
                  end
               end
            end
         end
         NRM_PRODUCT: begin
            case (cnt_ff)
               6'd0:    uu00_in = 32'(pr);
               6'd1:    uu11_in = 32'(pr);
               6'd2:    uu22_in = 32'(pr);
               6'd3:    uu01_in = 32'(pr);
               6'd4:    uu02_in = 32'(pr);
               default: uu12_in = 32'(pr);
            endcase
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd5) begin
               state_in = NRM_READY;
            end
         end
         NRM_READY: begin
            state_in = NRM_READY;
         end
         default: begin
            state_in = NRM_SQUARE;
         end
      endcase

      // A register write restarts the whole sequence.
      if (start) begin
         state_in = NRM_SQUARE;
         comp_in  = '0;
         cnt_in   = '0;
         n2_in    = '0;
         err_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= NRM_SQUARE;
         comp_ff  <= '0;
         cnt_ff   <= '0;
         n2_ff    <= '0;
         err_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         comp_ff  <= comp_in;
         cnt_ff   <= cnt_in;
         n2_ff    <= n2_in;
         err_ff   <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      root_ff <= root_in;
      rem_ff  <= rem_in;
      num_ff  <= num_in;
      quo_ff  <= quo_in;
      u0_ff   <= u0_in;
      u1_ff   <= u1_in;
      u2_ff   <= u2_in;
      uu00_ff <= uu00_in;
      uu11_ff <= uu11_in;
      uu22_ff <= uu22_in;
      uu01_ff <= uu01_in;
      uu02_ff <= uu02_in;
      uu12_ff <= uu12_in;
   end

   always_comb begin
      axis.ready = state_ff == NRM_READY;
      axis.err   = err_ff;
      axis.u0    = u0_ff;
      axis.u1    = u1_ff;
      axis.u2    = u2_ff;
      axis.uu00  = uu00_ff;
      axis.uu11  = uu11_ff;
      axis.uu22  = uu22_ff;
      axis.uu01  = uu01_ff;
      axis.uu02  = uu02_ff;
      axis.uu12  = uu12_ff;
   end

endmodule

/* src/aavr_horner_step.sv */
module aavr_horner_step import aavr_pkg::*; #(
   parameter int DIV_SHIFT = 1,
   parameter int DIV_ODD   = 1
) (
   input  logic        clock,
   input  logic        en,
   input  logic [29:0] x2_in,
   input  logic [30:0] acc_in,
   output logic [29:0] x2_out,
   output logic [30:0] acc_out
);

   // Half the divisor k * 2^30, and floor(2^35 / odd factor) + 1.
   localparam logic [61:0] HALF_DIV = 62'(DIV_ODD) << (DIV_SHIFT + 29);
   localparam logic [35:0] RECIP    = 36'((64'd1 << 35) / DIV_ODD + 1);

   logic [29:0] x2a_ff, x2b_ff;
   logic [28:0] y_ff, y_in;
   logic [30:0] acc_ff, acc_nx;
   logic [61:0] prod;
   logic [64:0] qprod;

   // First stage: product with rounding offset, power-of-two part of the divisor.
   always_comb begin
      prod = 62'(x2_in) * 62'(acc_in) + HALF_DIV;
      y_in = 29'(prod >> (30 + DIV_SHIFT));
   end

   // Second stage: odd part of the divisor by reciprocal multiply.
   always_comb begin
      qprod  = y_ff * RECIP;
      acc_nx = ONE_Q30 - 31'(qprod >> 35);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         y_ff   <= y_in;
         x2a_ff <= x2_in;
         acc_ff <= acc_nx;
         x2b_ff <= x2a_ff;
      end
   end

   assign x2_out  = x2b_ff;
   assign acc_out = acc_ff;

endmodule

/* src/aavr_trig.sv */
module aavr_trig import aavr_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic signed [17:0] angle,
   output logic               out_valid,
   output logic signed [31:0] sin_q30,
   output logic signed [31:0] cos_q30,
   output logic signed [32:0] omc_q30
);

   logic [TRIG_LAT-1:0] vld_ff;

   logic [13:0]   tf1_ff, tf1_in;
   aavr_quad_type qs1_ff, qs1_in, qs2_ff, qs3_ff, qs4_ff, qs5_ff;
   aavr_quad_type qs_dly_ff [13];
   logic [30:0]   at2_ff, at2_in, at3_ff;
   logic [29:0]   bt2_ff, bt2_in;
   logic [12:0]   wq3_ff, wq3_in;
   logic [29:0]   x4_ff, x4_in, x5_ff, x2_5_ff, x2_5_in;
   logic [29:0]   x_dly_ff [12];
   logic [30:0]   so_ff, so_in, co_ff;
   logic signed [31:0] s_ff, s_in, c_ff, c_in;
   logic signed [32:0] omc_ff, omc_in;

   logic signed [19:0] ang_w, r_w;
   logic [16:0] r_u, t_u;
   logic [36:0] wprod;
   logic [59:0] xsq;
   logic [60:0] sprod;
   logic [29:0]  sx2 [7];
   logic [30:0]  sacc [7];
   logic [29:0]  cx2 [7];
   logic [30:0]  cacc [7];
   logic signed [31:0] s0, c0;

   // Reduce the angle to one octant, keeping quadrant and swap.
   always_comb begin
      ang_w = 20'(angle);
      if (ang_w < 0) begin
         r_w = (ang_w + DEG360_S < 0) ? ang_w + DEG720_S : ang_w + DEG360_S;
      end else if (ang_w >= DEG360_S) begin
         r_w = ang_w - DEG360_S;
      end else begin
         r_w = ang_w;
      end
      r_u = r_w[16:0];
      if (r_u >= DEG270) begin
         qs1_in.quad = 2'd3;
         t_u = r_u - DEG270;
      end else if (r_u >= DEG180) begin
         qs1_in.quad = 2'd2;
         t_u = r_u - DEG180;
      end else if (r_u >= DEG90) begin
         qs1_in.quad = 2'd1;
         t_u = r_u - DEG90;
      end else begin
         qs1_in.quad = 2'd0;
         t_u = r_u;
      end
      qs1_in.swap = t_u > DEG45;
      tf1_in = qs1_in.swap ? 14'(DEG90 - t_u) : 14'(t_u);
   end

   // Argument in radians: x = PI_INT*t + floor((PI_FRAC*t + PI_RND) / 184320).
   always_comb begin
      at2_in  = PI_INT * tf1_ff;
      bt2_in  = 30'(PI_FRAC) * 30'(tf1_ff) + PI_RND;
      wprod   = bt2_ff[29:12] * RECIP45;
      wq3_in  = 13'(wprod >> 24);
      x4_in   = 30'(at3_ff + 31'(wq3_ff));
      xsq     = x4_ff * x4_ff;
      x2_5_in = 30'((61'(xsq) + HALF_Q30) >> 30);
   end

   // Horner lanes for sine and cosine.
   assign sx2[0]  = x2_5_ff;
   assign sacc[0] = ONE_Q30;
   assign cx2[0]  = x2_5_ff;
   assign cacc[0] = ONE_Q30;

   for (genvar k = 0; k < 6; k++) begin : g_horner
      aavr_horner_step #(
         .DIV_SHIFT(HORNER_SHIFT[k]),
         .DIV_ODD  (SIN_ODD[k])
      ) u_sin (
         .clock  (clock),
         .en     (en),
         .x2_in  (sx2[k]),
         .acc_in (sacc[k]),
         .x2_out (sx2[k+1]),
         .acc_out(sacc[k+1])
      );
      aavr_horner_step #(
         .DIV_SHIFT(HORNER_SHIFT[k]),
         .DIV_ODD  (COS_ODD[k])
      ) u_cos (
         .clock  (clock),
         .en     (en),
         .x2_in  (cx2[k]),
         .acc_in (cacc[k]),
         .x2_out (cx2[k+1]),
         .acc_out(cacc[k+1])
      );
   end

   // Final sine product, then quadrant and swap mapping.
   always_comb begin
      sprod = x_dly_ff[11] * sacc[6];
      so_in = 31'((sprod + HALF_Q30) >> 30);
      if (qs_dly_ff[12].swap) begin
         s0 = $signed({1'b0, co_ff});
         c0 = $signed({1'b0, so_ff});
      end else begin
         s0 = $signed({1'b0, so_ff});
         c0 = $signed({1'b0, co_ff});
      end
      case (qs_dly_ff[12].quad)
         2'd0:    begin s_in = s0;  c_in = c0;  end
         2'd1:    begin s_in = c0;  c_in = -s0; end
         2'd2:    begin s_in = -s0; c_in = -c0; end
         default: begin s_in = -c0; c_in = s0;  end
      endcase
      omc_in = $signed({2'b00, ONE_Q30}) - 33'(c_in);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tf1_ff  <= tf1_in;
         qs1_ff  <= qs1_in;
         at2_ff  <= at2_in;
         bt2_ff  <= bt2_in;
         qs2_ff  <= qs1_ff;
         at3_ff  <= at2_ff;
         wq3_ff  <= wq3_in;
         qs3_ff  <= qs2_ff;
         x4_ff   <= x4_in;
         qs4_ff  <= qs3_ff;
         x5_ff   <= x4_ff;
         x2_5_ff <= x2_5_in;
         qs5_ff  <= qs4_ff;
         x_dly_ff[0]  <= x5_ff;
         qs_dly_ff[0] <= qs5_ff;
         for (int i = 1; i < 12; i++) begin
            x_dly_ff[i] <= x_dly_ff[i-1];
         end
         for (int i = 1; i < 13; i++) begin
            qs_dly_ff[i] <= qs_dly_ff[i-1];
         end
         so_ff  <= so_in;
         co_ff  <= cacc[6];
         s_ff   <= s_in;
         c_ff   <= c_in;
         omc_ff <= omc_in;
      end
   end

   // Valid bits travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[TRIG_LAT-2:0], in_valid};
      end
   end

   assign out_valid = vld_ff[TRIG_LAT-1];
   assign sin_q30   = s_ff;
   assign cos_q30   = c_ff;
   assign omc_q30   = omc_ff;

   // The cosine lane carries its own copy of x2; both copies must agree.
`ifndef SYNTHESIS
   a_lanes_agree: assert property (@(posedge clock) disable iff (reset)
      sx2[6] === cx2[6])
      else $error("sine and cosine lanes out of step");
`endif

endmodule

/* src/aavr_rotate.sv */
module aavr_rotate import aavr_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic signed [31:0] sin_q30,
   input  logic signed [31:0] cos_q30,
   input  logic signed [32:0] omc_q30,
   input  logic signed [17:0] vec_x,
   input  logic signed [17:0] vec_y,
   input  logic signed [17:0] vec_z,
   input  aavr_axis_type      axis,
   output logic               out_valid,
   output aavr_result_type    result
);

   logic [ROT_LAT-1:0] vld_ff;

   logic signed [33:0] t00_ff, t11_ff, t22_ff, t01_ff, t02_ff, t12_ff;
   logic signed [31:0] su0_ff, su1_ff, su2_ff, c1_ff;
   logic signed [17:0] v1_ff [3];
   logic signed [17:0] v2_ff [3];
   logic signed [33:0] r_ff [9];
   logic signed [33:0] r_in [9];
   logic signed [51:0] p_ff [9];
   aavr_result_type    res_ff, res_in;

   logic signed [53:0] row [3];
   logic signed [63:0] rnd [3];
   logic [18:0] sat [3];

   // Rotation matrix entries: (1-c)*uu, plus c on the diagonal, plus s*u off it.
   always_comb begin
      r_in[0] = t00_ff + 34'(c1_ff);
      r_in[1] = t01_ff - 34'(su2_ff);
      r_in[2] = t02_ff + 34'(su1_ff);
      r_in[3] = t01_ff + 34'(su2_ff);
      r_in[4] = t11_ff + 34'(c1_ff);
      r_in[5] = t12_ff - 34'(su0_ff);
      r_in[6] = t02_ff - 34'(su1_ff);
      r_in[7] = t12_ff + 34'(su0_ff);
      r_in[8] = t22_ff + 34'(c1_ff);
   end

   // Row sums, rounding and saturation; a zero axis forces a zero result.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         row[i] = 54'(p_ff[3*i]) + 54'(p_ff[3*i+1]) + 54'(p_ff[3*i+2]);
         rnd[i] = rsh30(64'(row[i]));
         if (rnd[i] > OUT_MAX) begin
            sat[i] = 19'(OUT_MAX);
         end else if (rnd[i] < OUT_MIN) begin
            sat[i] = 19'(OUT_MIN);
         end else begin
            sat[i] = 19'(rnd[i]);
         end
      end
      res_in.err = axis.err;
      res_in.x   = axis.err ? '0 : sat[0];
      res_in.y   = axis.err ? '0 : sat[1];
      res_in.z   = axis.err ? '0 : sat[2];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t00_ff <= 34'(rsh30(64'(omc_q30) * 64'(axis.uu00)));
         t11_ff <= 34'(rsh30(64'(omc_q30) * 64'(axis.uu11)));
         t22_ff <= 34'(rsh30(64'(omc_q30) * 64'(axis.uu22)));
         t01_ff <= 34'(rsh30(64'(omc_q30) * 64'(axis.uu01)));
         t02_ff <= 34'(rsh30(64'(omc_q30) * 64'(axis.uu02)));
         t12_ff <= 34'(rsh30(64'(omc_q30) * 64'(axis.uu12)));
         su0_ff <= 32'(rsh30(64'(sin_q30) * 64'(axis.u0)));
         su1_ff <= 32'(rsh30(64'(sin_q30) * 64'(axis.u1)));
         su2_ff <= 32'(rsh30(64'(sin_q30) * 64'(axis.u2)));
         c1_ff  <= cos_q30;
         v1_ff[0] <= vec_x;
         v1_ff[1] <= vec_y;
         v1_ff[2] <= vec_z;
         v2_ff  <= v1_ff;
         r_ff   <= r_in;
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               p_ff[3*i+j] <= r_ff[3*i+j] * v2_ff[j];
            end
         end
         res_ff <= res_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[ROT_LAT-2:0], in_valid};
      end
   end

   assign out_valid = vld_ff[ROT_LAT-1];
   assign result    = res_ff;

endmodule
